// ===== hw/rtl/mchf_pkg.sv =====
// Package for the modifier combo hotkey filter.
// Holds the word types, state and register structs and event codes.
// No dependencies.
package mchf_pkg;

    // Event classes on the input and output words
    localparam logic [4:0] TYPE_SYNC   = 5'd0;
    localparam logic [4:0] TYPE_KEY    = 5'd1;
    localparam logic [4:0] TYPE_REPEAT = 5'd20;

    // Result kinds
    localparam logic [1:0] KIND_EVENT         = 2'd0;
    localparam logic [1:0] KIND_COMBO_PRESS   = 2'd1;
    localparam logic [1:0] KIND_COMBO_RELEASE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEFT_MOD  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_MOD = 2'd1;
    localparam logic [1:0] CFG_TRIGGER   = 2'd2;

    // Register reset values
    localparam logic [9:0] LEFT_MOD_RESET  = 10'd125;
    localparam logic [9:0] RIGHT_MOD_RESET = 10'd126;
    localparam logic [9:0] TRIGGER_RESET   = 10'd47;

    // Most result words one input word can cause
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [4:0]         event_type;
        logic [9:0]         key_code;
        logic signed [31:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [4:0]         out_type;
        logic [9:0]         out_code;
        logic signed [31:0] out_value;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [9:0] left_modifier_code;
        logic [9:0] right_modifier_code;
        logic [9:0] trigger_code;
    } mchf_cfg_t;

    typedef struct packed {
        logic left_mod_down;
        logic right_mod_down;
        logic left_mod_sent;
        logic right_mod_sent;
        logic left_mod_swallowed;
        logic right_mod_swallowed;
        logic trigger_held;
        logic combo_active;
    } mchf_state_t;

endpackage

// ===== hw/rtl/modifier_combo_hotkey_filter.sv =====
// Top level of the modifier combo hotkey filter: registers, result queue, output stage.
// Depends on mchf_pkg and mchf_core.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (in_item_t)
//   out      output     out_valid / out_ready  out_data  (out_item_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_index (2 bits), cfg_data (10 bits)
//
// An event is decoded in the cycle it is accepted; its 0 to 5 result words are loaded
// into a five-entry shift queue and drain one word per cycle through the output register
// while out_ready does not stall it. A new event is taken once the queue is empty or its
// last word moves out that cycle. cfg_ready is always high. Reset clears the filter state,
// queue and output valid, and loads the default key codes. A stalled out_ready holds the
// output word.
module modifier_combo_hotkey_filter
    import mchf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);

    mchf_cfg_t        cfg_reg;
    mchf_state_t      state_reg;
    mchf_state_t      state_next;
    out_item_t        core_res [MAX_RESULTS];
    logic [CNT_W-1:0] core_cnt;
    out_item_t        buf_reg  [MAX_RESULTS];
    logic [CNT_W-1:0] buf_cnt_reg;
    out_item_t        out_data_reg;
    logic             out_valid_reg;
    logic             move;
    logic             accept;

    mchf_core u_core (
        .item       (in_data),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .results    (core_res),
        .result_cnt (core_cnt)
    );

    // Handshake decisions
    assign move      = (buf_cnt_reg != '0) && (!out_valid_reg || out_ready);
    assign in_ready  = (buf_cnt_reg == '0) || ((buf_cnt_reg == CNT_W'(1)) && move);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Write configuration registers; ignore unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_modifier_code  <= LEFT_MOD_RESET;
            cfg_reg.right_modifier_code <= RIGHT_MOD_RESET;
            cfg_reg.trigger_code        <= TRIGGER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEFT_MOD:  cfg_reg.left_modifier_code  <= cfg_data;
                CFG_RIGHT_MOD: cfg_reg.right_modifier_code <= cfg_data;
                CFG_TRIGGER:   cfg_reg.trigger_code        <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Advance filter state on each accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Load or shift the result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_cnt_reg <= '0;
        end
        else if (accept)
        begin
            buf_cnt_reg <= core_cnt;
        end
        else if (move)
        begin
            buf_cnt_reg <= buf_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= core_res;
        end
        else if (move)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

    // Output register: take the queue head, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= buf_reg[0];
        end
    end

    // Queue never holds more than MAX_RESULTS words, one event's worth
    assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("result queue count out of range");

    // Events are only taken when the queue is empty or drains this cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (buf_cnt_reg == '0) || (buf_cnt_reg == CNT_W'(1) && move))
        else $error("event accepted over pending results");

    // An event with no results leaves the queue empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && core_cnt == '0) |=> (buf_cnt_reg == '0))
        else $error("dropped event left words in queue");

    // The last word in the queue closes its event
    assert property (@(posedge clk) disable iff (!rst_n)
        (buf_cnt_reg == CNT_W'(1)) |-> buf_reg[0].last)
        else $error("final queued word not marked last");

    // A combo press word is never followed by another press without release
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && state_reg.combo_active) |-> !(core_res[0].result_kind == KIND_COMBO_PRESS
            && core_cnt != '0))
        else $error("combo press while combo active");

endmodule

// ===== hw/rtl/mchf_core.sv =====
// Combinational event decode for the modifier combo hotkey filter.
// Produces the packed list of result words and the next filter state.
// Depends on mchf_pkg.
module mchf_core
    import mchf_pkg::*;
(
    input  in_item_t    item,
    input  mchf_cfg_t   cfg,
    input  mchf_state_t state_cur,
    output mchf_state_t state_next,
    output out_item_t   results [MAX_RESULTS],
    output logic [CNT_W-1:0] result_cnt
);

    function automatic out_item_t mk(input logic [1:0] kind, input logic [4:0] typ,
                                     input logic [9:0] code, input logic signed [31:0] val);
        out_item_t r;
        r.result_kind = kind;
        r.out_type    = typ;
        r.out_code    = code;
        r.out_value   = val;
        r.last        = 1'b0;
        return r;
    endfunction

    localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
    localparam logic signed [31:0] VAL_PRESS   = 32'sd1;

    always_comb
    begin
        logic [CNT_W-1:0] n;
        mchf_state_t      st;
        logic             down;
        logic             press;
        logic             hit_l;
        logic             hit_r;
        logic             hit_t;
        logic             is_mod;
        logic             any_mod;
        logic             was_active;
        logic             pass;

        n          = '0;
        st         = state_cur;
        pass       = 1'b1;
        down       = (item.key_value != VAL_RELEASE);
        press      = (item.key_value == VAL_PRESS);
        hit_l      = (item.key_code == cfg.left_modifier_code);
        hit_r      = (item.key_code == cfg.right_modifier_code);
        hit_t      = (item.key_code == cfg.trigger_code);
        is_mod     = hit_l || hit_r;
        was_active = state_cur.combo_active;
        any_mod    = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            results[i] = mk(KIND_EVENT, TYPE_SYNC, 10'd0, VAL_RELEASE);
        end

        if (item.event_type == TYPE_KEY)
        begin
            // Track held keys
            if (hit_l) st.left_mod_down  = down;
            if (hit_r) st.right_mod_down = down;
            if (hit_t) st.trigger_held   = down;
            any_mod = st.left_mod_down || st.right_mod_down;

            if (!was_active && hit_t && press && any_mod)
            begin
                // Combo start: retract sent modifiers, swallow held ones
                st.combo_active = 1'b1;
                pass = 1'b0;
                if (st.left_mod_sent)
                begin
                    results[n] = mk(KIND_EVENT, TYPE_KEY, cfg.left_modifier_code, VAL_RELEASE);
                    n = n + 1'b1;
                    results[n] = mk(KIND_EVENT, TYPE_SYNC, 10'd0, VAL_RELEASE);
                    n = n + 1'b1;
                    st.left_mod_sent = 1'b0;
                end
                if (st.right_mod_sent)
                begin
                    results[n] = mk(KIND_EVENT, TYPE_KEY, cfg.right_modifier_code,
                                    VAL_RELEASE);
                    n = n + 1'b1;
                    results[n] = mk(KIND_EVENT, TYPE_SYNC, 10'd0, VAL_RELEASE);
                    n = n + 1'b1;
                    st.right_mod_sent = 1'b0;
                end
                st.left_mod_swallowed  = st.left_mod_down;
                st.right_mod_swallowed = st.right_mod_down;
                results[n] = mk(KIND_COMBO_PRESS, TYPE_SYNC, 10'd0, VAL_RELEASE);
                n = n + 1'b1;
            end
            else if (was_active && (hit_t || is_mod))
            begin
                // Consume combo keys while the combo is live
                pass = 1'b0;
            end
            else if (!was_active && is_mod)
            begin
                // Hold back modifier; replay it on a lone release
                pass = 1'b0;
                if (item.key_value == VAL_RELEASE)
                begin
                    if (hit_l ? st.left_mod_swallowed : st.right_mod_swallowed)
                    begin
                        if (hit_l) st.left_mod_swallowed  = 1'b0;
                        else       st.right_mod_swallowed = 1'b0;
                    end
                    else if (hit_l ? st.left_mod_sent : st.right_mod_sent)
                    begin
                        results[n] = mk(KIND_EVENT, TYPE_KEY, item.key_code, VAL_RELEASE);
                        n = n + 1'b1;
                        results[n] = mk(KIND_EVENT, TYPE_SYNC, 10'd0, VAL_RELEASE);
                        n = n + 1'b1;
                        if (hit_l) st.left_mod_sent  = 1'b0;
                        else       st.right_mod_sent = 1'b0;
                    end
                    else
                    begin
                        results[n] = mk(KIND_EVENT, TYPE_KEY, item.key_code, VAL_PRESS);
                        n = n + 1'b1;
                        results[n] = mk(KIND_EVENT, TYPE_SYNC, 10'd0, VAL_RELEASE);
                        n = n + 1'b1;
                        results[n] = mk(KIND_EVENT, TYPE_KEY, item.key_code, VAL_RELEASE);
                        n = n + 1'b1;
                        results[n] = mk(KIND_EVENT, TYPE_SYNC, 10'd0, VAL_RELEASE);
                        n = n + 1'b1;
                    end
                end
            end
            else if (!was_active && down)
            begin
                // Another key went down: replay held modifiers first
                if (st.left_mod_down && !st.left_mod_sent)
                begin
                    results[n] = mk(KIND_EVENT, TYPE_KEY, cfg.left_modifier_code, VAL_PRESS);
                    n = n + 1'b1;
                    results[n] = mk(KIND_EVENT, TYPE_SYNC, 10'd0, VAL_RELEASE);
                    n = n + 1'b1;
                    st.left_mod_sent = 1'b1;
                end
                if (st.right_mod_down && !st.right_mod_sent)
                begin
                    results[n] = mk(KIND_EVENT, TYPE_KEY, cfg.right_modifier_code, VAL_PRESS);
                    n = n + 1'b1;
                    results[n] = mk(KIND_EVENT, TYPE_SYNC, 10'd0, VAL_RELEASE);
                    n = n + 1'b1;
                    st.right_mod_sent = 1'b1;
                end
            end

            // End the combo once either side lets go
            if (was_active && (!any_mod || !st.trigger_held))
            begin
                st.combo_active = 1'b0;
                results[n] = mk(KIND_COMBO_RELEASE, TYPE_SYNC, 10'd0, VAL_RELEASE);
                n = n + 1'b1;
            end
        end
        else if (item.event_type != TYPE_SYNC && item.event_type != TYPE_REPEAT)
        begin
            // Drop other event classes
            pass = 1'b0;
        end

        if (pass)
        begin
            results[n] = mk(KIND_EVENT, item.event_type, item.key_code, item.key_value);
            n = n + 1'b1;
        end

        // Mark the final word of this event
        if (n != '0)
        begin
            results[n - 1'b1].last = 1'b1;
        end

        state_next = st;
        result_cnt = n;
    end

endmodule
